// ===== sv/fru_pkg.sv =====
// fru_pkg: shared types for the fraction reduce unit.
// No dependencies.
`timescale 1ns / 1ps

package fru_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIVN,
    ST_DIVD
  } fru_state_e;

endpackage

// ===== sv/fraction_reduce_unit.sv =====
// fraction_reduce_unit: reduces a signed fraction to lowest terms, positive denominator.
// Depends on fru_pkg (sequencer states).
`timescale 1ns / 1ps

// Usage
//   A request (num_in_i, den_in_i) is taken at a rising edge with start high and
//   busy low. Only the low DATA_WIDTH bits of each operand count; the most
//   negative value is saturated to its neighbour before use.
//   The result (num_out_o, den_out_o, div_zero_o) is shown for exactly one cycle
//   with done_o high; the receiver cannot hold it off. busy is low in that cycle,
//   so a new request may be taken at the edge that ends it.
//   Zero denominator: div_zero_o set, both parts zero, done_o in the next cycle.
//   Otherwise one shared comparator and subtractor serves the GCD and divisions:
//     binary GCD  : one step per cycle
//     rescale     : the gcd is doubled once per common factor of two
//     two restoring divisions : numerator, then denominator, by the gcd
//   One request at a time.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops done_o.

module fraction_reduce_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] num_in_i,
  input  logic [63:0] den_in_i,
  output logic        done_o,
  output logic [63:0] num_out_o,
  output logic [62:0] den_out_o,
  output logic        div_zero_o
);

  localparam int MW = DATA_WIDTH - 1;
  localparam int CW = $clog2(MW);
  localparam logic [DATA_WIDTH-1:0] MinVal = DATA_WIDTH'(1) << MW;
  localparam logic [DATA_WIDTH-1:0] MinSat = MinVal | DATA_WIDTH'(1);
  localparam logic [CW-1:0] LastStep = CW'(MW - 1);

  fru_pkg::fru_state_e state_q, state_d;

  logic [MW-1:0] a_q, a_d, b_q, b_d;
  logic [MW-1:0] un_q, un_d, ud_q, ud_d;
  logic [MW-1:0] rem_q, rem_d, dvd_q, dvd_d, qn_q, qn_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic          done_q, done_d, dz_q, dz_d;
  logic [63:0]   num_out_q, num_out_d;
  logic [62:0]   den_out_q, den_out_d;

  // operand conditioning
  logic [DATA_WIDTH-1:0] nw, dw, nws, dws, nmag, dmag;

  always_comb begin
    nw   = num_in_i[DATA_WIDTH-1:0];
    dw   = den_in_i[DATA_WIDTH-1:0];
    nws  = (nw == MinVal) ? MinSat : nw;
    dws  = (dw == MinVal) ? MinSat : dw;
    nmag = nws[MW] ? (~nws + DATA_WIDTH'(1)) : nws;
    dmag = dws[MW] ? (~dws + DATA_WIDTH'(1)) : dws;
  end

  // shared compare / subtract unit
  logic          a_ge_b;
  logic [MW:0]   op_a, op_b;
  logic [MW+1:0] diff;
  logic          borrow;

  always_comb begin
    a_ge_b = a_q >= b_q;
    if (state_q == fru_pkg::ST_GCD) begin
      op_a = a_ge_b ? {1'b0, a_q} : {1'b0, b_q};
      op_b = a_ge_b ? {1'b0, b_q} : {1'b0, a_q};
    end else begin
      op_a = {rem_q, dvd_q[MW-1]};
      op_b = {1'b0, b_q};
    end
    diff   = {1'b0, op_a} - {1'b0, op_b};
    borrow = diff[MW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fru_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    un_q      <= un_d;
    ud_q      <= ud_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    qn_q      <= qn_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    dz_q      <= dz_d;
    num_out_q <= num_out_d;
    den_out_q <= den_out_d;
  end

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    un_d      = un_q;
    ud_d      = ud_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    qn_d      = qn_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    dz_d      = dz_q;
    num_out_d = num_out_q;
    den_out_d = den_out_q;
    done_d    = 1'b0;

    unique case (state_q)
      fru_pkg::ST_IDLE: begin
        if (start) begin
          if (dw == '0) begin
            num_out_d = '0;
            den_out_d = '0;
            dz_d      = 1'b1;
            done_d    = 1'b1;
          end else begin
            un_d    = nmag[MW-1:0];
            ud_d    = dmag[MW-1:0];
            a_d     = nmag[MW-1:0];
            b_d     = dmag[MW-1:0];
            neg_d   = nws[MW] ^ dws[MW];
            k_d     = '0;
            state_d = fru_pkg::ST_GCD;
          end
        end
      end

      fru_pkg::ST_GCD: begin
        priority if (a_q == '0) begin
          state_d = fru_pkg::ST_SCALE;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + CW'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_ge_b) begin
          a_d = diff[MW:1];
        end else begin
          b_d = diff[MW:1];
        end
      end

      fru_pkg::ST_SCALE: begin
        // b becomes the gcd and stays as divisor
        if (k_q == '0) begin
          rem_d   = '0;
          dvd_d   = un_q;
          cnt_d   = '0;
          state_d = fru_pkg::ST_DIVN;
        end else begin
          b_d = b_q << 1;
          k_d = k_q - CW'(1);
        end
      end

      fru_pkg::ST_DIVN: begin
        rem_d = borrow ? op_a[MW-1:0] : diff[MW-1:0];
        dvd_d = {dvd_q[MW-2:0], ~borrow};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LastStep) begin
          qn_d    = {dvd_q[MW-2:0], ~borrow};
          rem_d   = '0;
          dvd_d   = ud_q;
          cnt_d   = '0;
          state_d = fru_pkg::ST_DIVD;
        end
      end

      fru_pkg::ST_DIVD: begin
        rem_d = borrow ? op_a[MW-1:0] : diff[MW-1:0];
        dvd_d = {dvd_q[MW-2:0], ~borrow};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LastStep) begin
          num_out_d = neg_q ? (64'd0 - 64'(qn_q)) : 64'(qn_q);
          den_out_d = 63'({dvd_q[MW-2:0], ~borrow});
          dz_d      = 1'b0;
          done_d    = 1'b1;
          state_d   = fru_pkg::ST_IDLE;
        end
      end

      default: state_d = fru_pkg::ST_IDLE;
    endcase
  end

  assign busy       = state_q != fru_pkg::ST_IDLE;
  assign done_o     = done_q;
  assign num_out_o  = num_out_q;
  assign den_out_o  = den_out_q;
  assign div_zero_o = dz_q;

endmodule

// ===== sv/fru_checker.sv =====
// fru_checker: port-level assertions for fraction_reduce_unit, bound into every instance of it.
// Depends on fraction_reduce_unit port names.
`timescale 1ns / 1ps

module fru_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [63:0] num_out_o,
  input logic [62:0] den_out_o,
  input logic        div_zero_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_request_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither busy nor answered");

  a_zero_den_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_zero_o) |-> (num_out_o == 64'd0 && den_out_o == 63'd0))
    else $error("error result not zeroed");

  a_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !div_zero_o) |-> (den_out_o != 63'd0))
    else $error("zero denominator without error flag");

  a_busy_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("request finished without result");

endmodule

bind fraction_reduce_unit fru_checker u_fru_checker (.*);

// ===== tb/fraction_reduce_unit_test.sv =====
// fraction_reduce_unit_test: self-checking bench for fraction_reduce_unit, reduction by GCD.
// Queue-fed request driver with bursty idling, result monitor against an in-bench predictor.
// Depends on sv/fraction_reduce_unit.sv and, through it, sv/fru_pkg.sv.
`timescale 1ns / 1ps

module fraction_reduce_unit_test;

  localparam int W = 64;
  localparam int N_RANDOM = 1000;
  localparam int TAIL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_EVERY = 300;
  localparam int MAX_PRINTED = 20;

  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
  } frac_req_t;

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic        dz;
  } frac_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] num_in_i = '0;
  logic [63:0] den_in_i = '0;
  logic        done_o;
  logic [63:0] num_out_o;
  logic [62:0] den_out_o;
  logic        div_zero_o;

  frac_req_t request_q[$];
  frac_res_t expected_fracs[$];

  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned zero_den_cnt = 0;
  int unsigned directed_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  fraction_reduce_unit #(
    .DATA_WIDTH(W)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .num_in_i  (num_in_i),
    .den_in_i  (den_in_i),
    .done_o    (done_o),
    .num_out_o (num_out_o),
    .den_out_o (den_out_o),
    .div_zero_o(div_zero_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] clamp_operand(logic [63:0] raw);
    logic [63:0] mask;
    logic [63:0] sgn;
    logic [63:0] v;
    mask = {64{1'b1}} >> (64 - W);
    sgn  = 64'd1 << (W - 1);
    v    = raw & mask;
    if (v == sgn) v = sgn + 64'd1;
    if ((v & sgn) != 64'd0) v = v | ~mask;
    return v;
  endfunction

  function automatic frac_res_t reduce_fraction(logic [63:0] n_raw, logic [63:0] d_raw);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] qn;
    logic [63:0] qd;
    logic        neg;
    frac_res_t   res;
    n = clamp_operand(n_raw);
    d = clamp_operand(d_raw);
    if (d == 64'd0) begin
      res.num = '0;
      res.den = '0;
      res.dz  = 1'b1;
      return res;
    end
    neg = n[63] ^ d[63];
    un  = n[63] ? -n : n;
    ud  = d[63] ? -d : d;
    a   = un;
    b   = ud;
    while (b != 64'd0) begin
      r = a % b;
      a = b;
      b = r;
    end
    qn = un / a;
    qd = ud / a;
    res.num = neg ? -qn : qn;
    res.den = qd[62:0];
    res.dz  = 1'b0;
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_sign(logic [63:0] v);
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  task automatic add_request(logic [63:0] n, logic [63:0] d);
    frac_req_t rq;
    rq.num = n;
    rq.den = d;
    request_q.push_back(rq);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_cnt++;
    if (error_cnt <= MAX_PRINTED)
      $display("MISMATCH result %0d: %s got %h want %h", checked_cnt, what, got, want);
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_p
    frac_res_t exp_res;
    frac_req_t rq;
    logic      go;
    if (rst_ni) begin
      if (start && !busy) begin
        exp_res = reduce_fraction(num_in_i, den_in_i);
        expected_fracs.push_back(exp_res);
        accepted_cnt++;
        if (exp_res.dz) zero_den_cnt++;
      end
      if (!(start && busy)) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0 &&
                     !(accepted_cnt % DRAIN_EVERY == 0 && accepted_cnt != checked_cnt)) begin
          go = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6:    gap_left = $urandom_range(1, 4);
              default:    gap_left = $urandom_range(1, 320);
            endcase
          end
        end
        if (go) begin
          rq = request_q.pop_front();
          num_in_i <= rq.num;
          den_in_i <= rq.den;
          start    <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : watch_p
    frac_res_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_fracs.size() == 0) begin
        report_mismatch("unrequested result, num", num_out_o, '0);
      end else begin
        exp_res = expected_fracs.pop_front();
        if (num_out_o !== exp_res.num) report_mismatch("num_out", num_out_o, exp_res.num);
        if (den_out_o !== exp_res.den)
          report_mismatch("den_out", {1'b0, den_out_o}, {1'b0, exp_res.den});
        if (div_zero_o !== exp_res.dz)
          report_mismatch("div_zero", {63'd0, div_zero_o}, {63'd0, exp_res.dz});
        checked_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_fracs.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stim_p
    logic [63:0] g;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] specials[8];
    specials = '{64'd0, 64'd1, {64{1'b1}}, MAX_POS, -MAX_POS, MOST_NEG,
                 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000};

    // directed: zero cases, signs, extremes, most negative saturation
    add_request(64'd0, 64'd0);
    add_request(64'd5, 64'd0);
    add_request(MOST_NEG, 64'd0);
    add_request(64'd0, 64'd5);
    add_request(64'd0, -64'd7);
    add_request(MAX_POS, MAX_POS);
    add_request(MAX_POS, -64'd1);
    add_request(-MAX_POS, 64'd1);
    add_request(MOST_NEG, 64'd1);
    add_request(64'd1, MOST_NEG);
    add_request(MOST_NEG, MOST_NEG);
    add_request(MOST_NEG, MAX_POS);
    add_request(64'd6, -64'd4);
    add_request(-64'd6, -64'd4);
    add_request(-64'd6, 64'd4);
    add_request(64'd1, 64'd1);
    add_request({64{1'b1}}, {64{1'b1}});
    add_request(64'd12, 64'd18);
    add_request(64'h4000_0000_0000_0000, 64'h2000_0000_0000_0000);
    add_request(64'h7FFF_FFFF_FFFF_FFE7, 64'h3FFF_FFFF_FFFF_FFFF);
    add_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    add_request(-64'd3, MAX_POS);
    directed_cnt = request_q.size();

    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0, 1: add_request(rand_word(), rand_word());
        2, 3, 4: begin
          g = 64'($urandom) + 64'd1;
          a = 64'($urandom_range(0, 32'h3FFF_FFFF)) * g;
          b = 64'($urandom_range(1, 32'h3FFF_FFFF)) * g;
          add_request(rand_sign(a), rand_sign(b));
        end
        5: begin
          a = 64'($urandom_range(0, 32'h000F_FFFF)) << $urandom_range(0, 42);
          b = 64'($urandom_range(1, 32'h000F_FFFF)) << $urandom_range(0, 42);
          add_request(rand_sign(a), rand_sign(b));
        end
        6: add_request(64'($signed($urandom_range(0, 32)) - 16),
                       64'($signed($urandom_range(0, 32)) - 16));
        7: begin
          if ($urandom_range(0, 1) == 1) add_request(rand_word(), 64'd0);
          else add_request(64'd0, rand_word());
        end
        8: begin
          if ($urandom_range(0, 1) == 1)
            add_request(specials[$urandom_range(0, 7)], specials[$urandom_range(0, 7)]);
          else if ($urandom_range(0, 1) == 1)
            add_request(specials[$urandom_range(0, 7)], rand_word());
          else
            add_request(rand_word(), specials[$urandom_range(0, 7)]);
        end
        default: begin
          b = rand_word() >> 24;
          a = b * 64'($urandom_range(1, 32'h000F_FFFF));
          if ($urandom_range(0, 1) == 1) add_request(rand_sign(a), rand_sign(b));
          else add_request(rand_sign(b), rand_sign(a));
        end
      endcase
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (request_q.size() != 0 || start) @(posedge clk_i);
    while (expected_fracs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d directed, %0d with zero denominator), checked %0d results",
             accepted_cnt, directed_cnt, zero_den_cnt, checked_cnt);
    $display("Mixed random, common-factor, power-of-two and extreme operands; %0d mismatches",
             error_cnt);
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
